FILE: rtl/msdrt_pkg.sv
// package for the multi-slot delay/repeat timer
// holds shared types, opcodes, state encoding and default sizes; no dependencies
`default_nettype none

package msdrt_pkg;

    // default sizes for the top-level parameters
    localparam int unsigned DEF_NUM_SLOTS = 16;
    localparam int unsigned DEF_TIME_BITS = 32;

    // fixed field widths
    localparam int unsigned OP_W     = 2;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned DELAY_W  = 24;
    localparam int unsigned IVL_W    = 24;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned OWNER_W  = 16;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned IN_DATA_W  = 104;
    localparam int unsigned OUT_DATA_W = 112;

    // item opcodes
    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_EVAL  = 2'd2,
        ST_FLUSH = 2'd3
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic ready;       // input channel may take an item
        logic take_item;   // item accepted this cycle
        logic issue_read;  // read slot tables at scan index
        logic evaluate;    // examine the slot whose tables were read
        logic flush;       // hand the held result on as the final one
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic tick_item;   // offered item is a tick
        logic scan_end;    // scan index is at the last slot
        logic eval_done;   // slot examination finished this cycle
        logic flush_done;  // nothing left held for this tick
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/multi_slot_delay_repeat_timer_top.sv
// top level of the multi-slot delay/repeat timer
// depends on msdrt_pkg, msdrt_ctrl and msdrt_dp
//
// channel   dir  signals                          content
// s_axis    in   i_s_tvalid o_s_tready i_s_tdata  start, stop or tick item
// m_axis    out  o_m_tvalid i_m_tready o_m_tdata  one expiry, tlast on the last of a tick
//                o_m_tlast
//
// start and stop are taken in idle; a tick runs the slot scan and then a flush,
// the scan reading the slot tables through one registered port
// (a read state, then an examine and write-back state per slot)
// reset clears the tick counter and every slot's active and delay flags
// a stalled result output holds the scan once a second firing slot is found
`default_nettype none

module multi_slot_delay_repeat_timer_top
    import msdrt_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int unsigned TIME_BITS = DEF_TIME_BITS
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    // op[1:0] timer_slot[5:2] repeat_req[6] delay[30:7] interval[54:31]
    // custom[86:55] owner[102:87] zero[103]
    input  wire [IN_DATA_W-1:0]   i_s_tdata,
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    // fired_slot[3:0] user_word[35:4] destination[51:36] fire_count[83:52]
    // period[107:84] zero[111:108]
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    t_cmd    cmd;
    t_status status;

    logic [SLOT_W-1:0]  fired_slot;
    logic [WORD_W-1:0]  user_word;
    logic [OWNER_W-1:0] destination;
    logic [COUNT_W-1:0] fire_count;
    logic [IVL_W-1:0]   period;

    // sequencer
    msdrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    msdrt_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_op          (i_s_tdata[1:0]),
        .i_timer_slot  (i_s_tdata[5:2]),
        .i_repeat_req  (i_s_tdata[6]),
        .i_delay       (i_s_tdata[30:7]),
        .i_interval    (i_s_tdata[54:31]),
        .i_custom      (i_s_tdata[86:55]),
        .i_owner       (i_s_tdata[102:87]),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_fired_slot  (fired_slot),
        .o_user_word   (user_word),
        .o_destination (destination),
        .o_fire_count  (fire_count),
        .o_period      (period),
        .o_last        (o_m_tlast)
    );

    // result packing
    assign o_s_tready = cmd.ready;
    assign o_m_tdata  = {4'd0, period, fire_count, destination, user_word, fired_slot};

endmodule

`default_nettype wire

FILE: rtl/msdrt_ctrl.sv
// sequencer for the timer: idle, per-slot read and evaluate, final flush
// depends on msdrt_pkg
`default_nettype none

module msdrt_ctrl
    import msdrt_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && i_status.tick_item) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_status.eval_done) begin
                    n_state = i_status.scan_end ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH: begin
                if (i_status.flush_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // commands, input held off while reset is asserted
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.ready     = i_rst_n;
                o_cmd.take_item = i_s_tvalid && i_rst_n;
            end
            ST_READ: begin
                o_cmd.issue_read = 1'b1;
            end
            ST_EVAL: begin
                o_cmd.evaluate = 1'b1;
            end
            ST_FLUSH: begin
                o_cmd.flush = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/msdrt_dp.sv
// datapath for the timer: tick counter, slot tables, scan index,
// held result and output register; depends on msdrt_pkg
`default_nettype none

module msdrt_dp
    import msdrt_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int unsigned TIME_BITS = DEF_TIME_BITS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire t_cmd            i_cmd,
    output t_status              o_status,
    // input item fields
    input  wire [OP_W-1:0]       i_op,
    input  wire [SLOT_W-1:0]     i_timer_slot,
    input  wire                  i_repeat_req,
    input  wire [DELAY_W-1:0]    i_delay,
    input  wire [IVL_W-1:0]      i_interval,
    input  wire [WORD_W-1:0]     i_custom,
    input  wire [OWNER_W-1:0]    i_owner,
    // result channel
    input  wire                  i_m_tready,
    output logic                 o_m_tvalid,
    output logic [SLOT_W-1:0]    o_fired_slot,
    output logic [WORD_W-1:0]    o_user_word,
    output logic [OWNER_W-1:0]   o_destination,
    output logic [COUNT_W-1:0]   o_fire_count,
    output logic [IVL_W-1:0]     o_period,
    output logic                 o_last
);

    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned CMP_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

    // slot tables
    logic                 mem_periodic [NUM_SLOTS];
    logic [TIME_BITS-1:0] mem_due      [NUM_SLOTS];
    logic [TIME_BITS-1:0] mem_next     [NUM_SLOTS];
    logic [IVL_W-1:0]     mem_period   [NUM_SLOTS];
    logic [WORD_W-1:0]    mem_user     [NUM_SLOTS];
    logic [OWNER_W-1:0]   mem_owner    [NUM_SLOTS];
    logic [COUNT_W-1:0]   mem_count    [NUM_SLOTS];

    // registered read data
    logic                 r_rd_periodic;
    logic [TIME_BITS-1:0] r_rd_due;
    logic [TIME_BITS-1:0] r_rd_next;
    logic [IVL_W-1:0]     r_rd_period;
    logic [WORD_W-1:0]    r_rd_user;
    logic [OWNER_W-1:0]   r_rd_owner;
    logic [COUNT_W-1:0]   r_rd_count;

    logic [NUM_SLOTS-1:0] r_active;
    logic [NUM_SLOTS-1:0] r_in_delay;
    logic [TIME_BITS-1:0] r_now;
    logic [IDX_W-1:0]     r_idx;

    // held result of this tick
    logic                 r_pend_valid;
    logic [SLOT_W-1:0]    r_pend_slot;
    logic [WORD_W-1:0]    r_pend_user;
    logic [OWNER_W-1:0]   r_pend_owner;
    logic [COUNT_W-1:0]   r_pend_count;
    logic [IVL_W-1:0]     r_pend_period;

    // output register
    logic                 r_out_valid;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [WORD_W-1:0]    r_out_user;
    logic [OWNER_W-1:0]   r_out_owner;
    logic [COUNT_W-1:0]   r_out_count;
    logic [IVL_W-1:0]     r_out_period;
    logic                 r_out_last;

    // item decode
    logic [CMP_W-1:0]     slot_ext;
    logic                 slot_ok;
    logic [IDX_W-1:0]     slot_idx;
    logic                 do_start;
    logic                 do_stop;
    logic                 do_tick;
    logic [TIME_BITS-1:0] dly_ext;
    logic [TIME_BITS-1:0] ivl_ext;
    logic [TIME_BITS-1:0] start_base;
    logic [TIME_BITS-1:0] start_due;
    logic [TIME_BITS-1:0] start_next;

    assign slot_ext   = CMP_W'(i_timer_slot);
    assign slot_ok    = slot_ext < CMP_W'(NUM_SLOTS);
    assign slot_idx   = slot_ext[IDX_W-1:0];
    assign do_start   = i_cmd.take_item && (i_op == OP_START) && slot_ok;
    assign do_stop    = i_cmd.take_item && (i_op == OP_STOP) && slot_ok;
    assign do_tick    = i_cmd.take_item && (i_op == OP_TICK);
    assign dly_ext    = TIME_BITS'(i_delay);
    assign ivl_ext    = TIME_BITS'(i_interval);
    assign start_base = r_now + ((i_delay != '0) ? dly_ext : ivl_ext);
    assign start_due  = start_base;
    assign start_next = (i_delay != '0) ? (start_base + ivl_ext) : start_base;

    // slot examination
    logic                 out_free;
    logic [TIME_BITS-1:0] since_due;
    logic                 hit;
    logic                 leave_delay;
    logic                 fire;
    logic                 fire_ok;
    logic                 eval_done;
    logic [COUNT_W-1:0]   new_count;
    logic [TIME_BITS-1:0] new_due;

    assign out_free    = !r_out_valid || i_m_tready;
    assign since_due   = r_now - r_rd_due;
    assign hit         = r_active[r_idx] && !since_due[TIME_BITS-1];
    assign leave_delay = i_cmd.evaluate && hit && r_in_delay[r_idx];
    assign fire        = i_cmd.evaluate && hit && !r_in_delay[r_idx];
    assign fire_ok     = fire && (!r_pend_valid || out_free);
    assign eval_done   = i_cmd.evaluate && (!fire || fire_ok);
    assign new_count   = (r_rd_count == '1) ? r_rd_count : (r_rd_count + 1'b1);
    assign new_due     = (r_rd_period == '0) ? r_now
                                             : (r_rd_due + TIME_BITS'(r_rd_period));

    // table write port, shared between start and evaluation
    logic [IDX_W-1:0] wr_addr;
    assign wr_addr = i_cmd.evaluate ? r_idx : slot_idx;

    always_ff @(posedge i_clk) begin
        if (do_start) begin
            mem_periodic[wr_addr] <= i_repeat_req;
            mem_next[wr_addr]     <= start_next;
            mem_period[wr_addr]   <= i_interval;
            mem_user[wr_addr]     <= i_custom;
            mem_owner[wr_addr]    <= i_owner;
        end
        if (do_start || fire_ok) begin
            mem_count[wr_addr] <= do_start ? '0 : new_count;
        end
        if (do_start || leave_delay || (fire_ok && r_rd_periodic)) begin
            mem_due[wr_addr] <= do_start ? start_due
                              : (leave_delay ? r_rd_next : new_due);
        end
    end

    // table read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue_read) begin
            r_rd_periodic <= mem_periodic[r_idx];
            r_rd_due      <= mem_due[r_idx];
            r_rd_next     <= mem_next[r_idx];
            r_rd_period   <= mem_period[r_idx];
            r_rd_user     <= mem_user[r_idx];
            r_rd_owner    <= mem_owner[r_idx];
            r_rd_count    <= mem_count[r_idx];
        end
    end

    // slot flags, tick counter and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_in_delay <= '0;
            r_now      <= '0;
            r_idx      <= '0;
        end else begin
            if (do_start) begin
                r_active[slot_idx]   <= 1'b1;
                r_in_delay[slot_idx] <= (i_delay != '0);
            end
            if (do_stop) begin
                r_active[slot_idx]   <= 1'b0;
                r_in_delay[slot_idx] <= 1'b0;
            end
            if (leave_delay) begin
                r_in_delay[r_idx] <= 1'b0;
            end
            if (fire_ok && !r_rd_periodic) begin
                r_active[r_idx] <= 1'b0;
            end
            if (do_tick) begin
                r_now <= r_now + 1'b1;
                r_idx <= '0;
            end else if (eval_done && (r_idx != IDX_W'(NUM_SLOTS - 1))) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // held result and output register control
    logic flush_move;
    assign flush_move = i_cmd.flush && r_pend_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (fire_ok) begin
                r_pend_valid <= 1'b1;
            end else if (flush_move) begin
                r_pend_valid <= 1'b0;
            end
            if ((fire_ok && r_pend_valid) || flush_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if ((fire_ok && r_pend_valid) || flush_move) begin
            r_out_slot   <= r_pend_slot;
            r_out_user   <= r_pend_user;
            r_out_owner  <= r_pend_owner;
            r_out_count  <= r_pend_count;
            r_out_period <= r_pend_period;
            r_out_last   <= flush_move;
        end
        if (fire_ok) begin
            r_pend_slot   <= SLOT_W'(r_idx);
            r_pend_user   <= r_rd_user;
            r_pend_owner  <= r_rd_owner;
            r_pend_count  <= new_count;
            r_pend_period <= r_rd_period;
        end
    end

    // status back to the sequencer
    always_comb begin
        o_status.tick_item  = (i_op == OP_TICK);
        o_status.scan_end   = (r_idx == IDX_W'(NUM_SLOTS - 1));
        o_status.eval_done  = eval_done;
        o_status.flush_done = !r_pend_valid || out_free;
    end

    assign o_m_tvalid    = r_out_valid;
    assign o_fired_slot  = r_out_slot;
    assign o_user_word   = r_out_user;
    assign o_destination = r_out_owner;
    assign o_fire_count  = r_out_count;
    assign o_period      = r_out_period;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for multi_slot_delay_repeat_timer_top
// depends on msdrt_pkg and the timer rtl; a directed table then random start, stop and tick
// items, with every expiry checked against a typed value or a predictor of the slot table

module testbench
    import msdrt_pkg::*;
();

    localparam int NSLOT       = 16;
    localparam int SCAN_CYCLES = 2 * NSLOT + 2;
    localparam int QUIET_LIMIT = 5000;
    localparam int RAND_ITEMS  = 500;
    localparam int HOLD_AT     = 175;
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_FROM   = 300;
    localparam int CALM_TO     = 380;

    // one input item, op in the lowest bits as on the bus
    typedef struct packed {
        logic [15:0] owner;
        logic [31:0] word;
        logic [23:0] ivl;
        logic [23:0] dly;
        logic        rep;
        logic [3:0]  slot;
        t_op         op;
    } t_timer_req;

    // one expiry, tlast above the tdata fields
    typedef struct packed {
        logic        last;
        logic [23:0] per;
        logic [31:0] count;
        logic [15:0] dest;
        logic [31:0] word;
        logic [3:0]  slot;
    } t_expiry;

    // directed row: n_fixed < 0 means the predictor supplies the expiries
    typedef struct {
        t_timer_req req;
        int         n_fixed;
        t_expiry    fixed;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;

    // predictor copy of the slot table
    logic [31:0] now_t;
    logic        tm_active   [NSLOT];
    logic        tm_in_delay [NSLOT];
    logic        tm_periodic [NSLOT];
    logic [31:0] tm_due      [NSLOT];
    logic [31:0] tm_next     [NSLOT];
    logic [23:0] tm_period   [NSLOT];
    logic [31:0] tm_word     [NSLOT];
    logic [15:0] tm_owner    [NSLOT];
    logic [31:0] tm_count    [NSLOT];

    t_expiry   expected_expiries[$];
    t_stim_row dir_rows[$];

    int  errors = 0;
    int  items_sent = 0;
    int  starts_sent = 0;
    int  stops_sent = 0;
    int  ticks_sent = 0;
    int  expiries_checked = 0;
    logic calm;
    logic rx_hold;

    multi_slot_delay_repeat_timer_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predictor: applies one accepted item, queues the expiries it causes when keep is set
    task automatic predict_expiries(input t_timer_req r, input bit keep);
        t_expiry     fired[$];
        t_expiry     e;
        logic [31:0] diff;
        int          i;
        case (r.op)
            OP_START: begin
                tm_active[r.slot]   = 1'b1;
                tm_periodic[r.slot] = r.rep;
                tm_period[r.slot]   = r.ivl;
                tm_word[r.slot]     = r.word;
                tm_owner[r.slot]    = r.owner;
                tm_count[r.slot]    = 32'd0;
                if (r.dly != 24'd0) begin
                    tm_in_delay[r.slot] = 1'b1;
                    tm_due[r.slot]      = now_t + {8'd0, r.dly};
                    tm_next[r.slot]     = tm_due[r.slot] + {8'd0, r.ivl};
                end else begin
                    tm_in_delay[r.slot] = 1'b0;
                    tm_due[r.slot]      = now_t + {8'd0, r.ivl};
                    tm_next[r.slot]     = tm_due[r.slot];
                end
            end
            OP_STOP: begin
                tm_active[r.slot]   = 1'b0;
                tm_in_delay[r.slot] = 1'b0;
            end
            OP_TICK: begin
                now_t = now_t + 32'd1;
                for (i = 0; i < NSLOT; i++) begin
                    diff = now_t - tm_due[i];
                    if (tm_active[i] && !diff[31]) begin
                        if (tm_in_delay[i]) begin
                            // delay deadline passes silently
                            tm_in_delay[i] = 1'b0;
                            tm_due[i]      = tm_next[i];
                        end else begin
                            if (tm_count[i] != 32'hFFFF_FFFF)
                                tm_count[i] = tm_count[i] + 32'd1;
                            e.slot  = 4'(i);
                            e.word  = tm_word[i];
                            e.dest  = tm_owner[i];
                            e.count = tm_count[i];
                            e.per   = tm_period[i];
                            e.last  = 1'b0;
                            fired = {fired, e};
                            if (!tm_periodic[i])
                                tm_active[i] = 1'b0;
                            else if (tm_period[i] == 24'd0)
                                tm_due[i] = now_t;
                            else
                                tm_due[i] = tm_due[i] + {8'd0, tm_period[i]};
                        end
                    end
                end
                if (fired.size() > 0)
                    fired[fired.size() - 1].last = 1'b1;
                if (keep)
                    expected_expiries = {expected_expiries, fired};
            end
            default: ;
        endcase
    endtask

    // append one row to the directed table
    task automatic add_row(input t_stim_row row);
        dir_rows = {dir_rows, row};
    endtask

    function automatic t_timer_req req(t_op op, int slot, bit rep, int dly, int ivl,
                                       logic [31:0] word, int owner);
        t_timer_req r;
        r.op    = op;
        r.slot  = 4'(slot);
        r.rep   = rep;
        r.dly   = 24'(dly);
        r.ivl   = 24'(ivl);
        r.word  = word;
        r.owner = 16'(owner);
        return r;
    endfunction

    // typed expiry, always the only one of its tick
    function automatic t_expiry fix(int slot, logic [31:0] word, int dest, int count, int per);
        t_expiry e;
        e.slot  = 4'(slot);
        e.word  = word;
        e.dest  = 16'(dest);
        e.count = 32'(count);
        e.per   = 24'(per);
        e.last  = 1'b1;
        return e;
    endfunction

    function automatic t_timer_req random_req();
        t_timer_req  r;
        int unsigned p;
        p = $urandom_range(99);
        if (p < 50)
            r.op = OP_TICK;
        else if (p < 80)
            r.op = OP_START;
        else if (p < 94)
            r.op = OP_STOP;
        else
            r.op = OP_NONE;
        r.slot = 4'($urandom_range(15));
        r.rep  = 1'($urandom_range(1));
        // mostly short deadlines so slots fire often
        p = $urandom_range(99);
        r.dly = (p < 60) ? 24'd0 : (p < 90) ? 24'($urandom_range(6, 1)) : 24'($urandom);
        p = $urandom_range(99);
        r.ivl = (p < 15) ? 24'd0 : (p < 80) ? 24'($urandom_range(10, 1)) : 24'($urandom);
        r.word  = $urandom;
        r.owner = 16'($urandom);
        return r;
    endfunction

    // offer one item, wait for the handshake, then predict
    task automatic send_req(input t_timer_req r, input int n_fixed, input t_expiry fixed);
        while (!calm && $urandom_range(99) < 32) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, r};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        case (r.op)
            OP_START: starts_sent++;
            OP_STOP:  stops_sent++;
            OP_TICK:  ticks_sent++;
            default: ;
        endcase
        if (n_fixed < 0) begin
            predict_expiries(r, 1'b1);
        end else begin
            predict_expiries(r, 1'b0);
            if (n_fixed > 0)
                expected_expiries = {expected_expiries, fixed};
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // expiry checker and receiver readiness
    always @(posedge i_clk) begin : expiry_monitor
        t_expiry got;
        t_expiry want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tlast, o_m_tdata[107:0]};
            if (expected_expiries.size() == 0) begin
                errors++;
                $display("%0t: unexpected expiry, expected none, actual %h", $time, got);
            end else begin
                want = expected_expiries.pop_front();
                check_field("fired_slot", want.slot, got.slot);
                check_field("user_word", want.word, got.word);
                check_field("destination", want.dest, got.dest);
                check_field("fire_count", want.count, got.count);
                check_field("period", want.per, got.per);
                check_field("last", want.last, got.last);
                expiries_checked++;
            end
        end
        i_m_tready <= i_rst_n && !rx_hold && (calm || $urandom_range(99) >= 32);
    end

    // one long receiver hold-off while items keep coming
    initial begin : rx_holdoff
        rx_hold <= 1'b0;
        @(posedge i_clk);
        while (items_sent < HOLD_AT) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // watchdog on cycles with no handshake on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles, %0d expiries outstanding",
                 $time, QUIET_LIMIT, expected_expiries.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int k;
        t_timer_req r;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_m_tready <= 1'b0;
        calm       <= 1'b0;
        now_t = 32'd0;
        for (k = 0; k < NSLOT; k++) begin
            tm_active[k]   = 1'b0;
            tm_in_delay[k] = 1'b0;
        end

        // directed table, counter starts at zero after reset
        add_row('{req(OP_TICK, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{req(OP_START, 0, 0, 0, 1, 32'hFFFF_FFFF, 'hFFFF), 0, '0});
        add_row('{req(OP_TICK, 0, 0, 0, 0, 0, 0), 1,
                  fix(0, 32'hFFFF_FFFF, 'hFFFF, 1, 1)});
        // periodic with zero interval fires on every tick
        add_row('{req(OP_START, 15, 1, 0, 0, 0, 0), 0, '0});
        add_row('{req(OP_TICK, 0, 0, 0, 0, 0, 0), 1, fix(15, 0, 0, 1, 0)});
        add_row('{req(OP_TICK, 0, 0, 0, 0, 0, 0), 1, fix(15, 0, 0, 2, 0)});
        add_row('{req(OP_STOP, 15, 0, 0, 0, 0, 0), 0, '0});
        // stopping an inactive slot
        add_row('{req(OP_STOP, 15, 1, 'hFFFFFF, 'hFFFFFF, '1, 'hFFFF), 0, '0});
        add_row('{req(OP_TICK, 0, 0, 0, 0, 0, 0), 0, '0});
        // delayed periodic: silent at the delay deadline, fires at delay plus interval
        add_row('{req(OP_START, 3, 1, 1, 2, 32'hA5A5_5A5A, 'h1234), 0, '0});
        add_row('{req(OP_TICK, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{req(OP_TICK, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{req(OP_TICK, 0, 0, 0, 0, 0, 0), 1,
                  fix(3, 32'hA5A5_5A5A, 'h1234, 1, 2)});
        // restart of an active slot, delay then zero interval
        add_row('{req(OP_START, 3, 0, 2, 0, 32'h0F0F_F0F0, 'hC3C3), -1, '0});
        add_row('{req(OP_TICK, 0, 0, 0, 0, 0, 0), -1, '0});
        add_row('{req(OP_TICK, 0, 0, 0, 0, 0, 0), -1, '0});
        add_row('{req(OP_TICK, 0, 0, 0, 0, 0, 0), -1, '0});
        // two slots due on one tick, tlast on the higher
        add_row('{req(OP_START, 1, 0, 0, 1, 32'h1111_1111, 'h0001), -1, '0});
        add_row('{req(OP_START, 2, 1, 0, 1, 32'h2222_2222, 'h0002), -1, '0});
        // unused opcode is ignored
        add_row('{req(OP_NONE, 15, 1, 'hFFFFFF, 'hFFFFFF, '1, 'hFFFF), -1, '0});
        add_row('{req(OP_TICK, 0, 0, 0, 0, 0, 0), -1, '0});
        add_row('{req(OP_START, 6, 1, 'hFFFFFF, 'hFFFFFF, 32'hDEAD_BEEF, 'h8000),
                  -1, '0});
        add_row('{req(OP_STOP, 2, 0, 0, 0, 0, 0), -1, '0});
        add_row('{req(OP_TICK, 0, 0, 0, 0, 0, 0), -1, '0});
        add_row('{req(OP_STOP, 6, 0, 0, 0, 0, 0), -1, '0});

        // reset
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n])
            send_req(dir_rows[n].req, dir_rows[n].n_fixed, dir_rows[n].fixed);

        // random items, ignored opcodes not counted
        k = 0;
        while (k < RAND_ITEMS) begin
            r = random_req();
            calm <= (k >= CALM_FROM && k < CALM_TO);
            send_req(r, -1, '0);
            if (r.op != OP_NONE)
                k++;
        end
        i_s_tvalid <= 1'b0;
        calm       <= 1'b0;

        // drain, then allow one more scan for stray expiries
        while (expected_expiries.size() != 0) @(posedge i_clk);
        repeat (SCAN_CYCLES + 16) @(posedge i_clk);

        $display("run: %0d items (%0d starts, %0d stops, %0d ticks), %0d expiries checked",
                 items_sent, starts_sent, stops_sent, ticks_sent, expiries_checked);
        $display("run: %0d mismatches, receiver held off for %0d cycles once",
                 errors, HOLD_CYCLES);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
rtl/msdrt_pkg.sv
rtl/msdrt_ctrl.sv
rtl/msdrt_dp.sv
rtl/multi_slot_delay_repeat_timer_top.sv
tb/testbench.sv
